@@ design/mat4m_pkg.sv @@
package mat4m_pkg;

  localparam int DATA_W  = 32;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int ACC_W   = PROD_W + 3;
  localparam int STEP_W  = 3;

  typedef struct packed {
    logic                     valid;
    logic [STEP_W-1:0]        step;
    logic signed [DATA_W-1:0] b;
  } tok_t;

  typedef struct packed {
    logic                     en;
    logic [STEP_W-1:0]        idx;
    logic signed [DATA_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] acc;
  } res_t;

endpackage

@@ design/mat4_multiply_core.sv @@
// The first product element leaves once feeding has begun after the final input pair
// is accepted; the rest follow one per cycle while m_axis_tready stays high.
// Each matrix takes DIM*DIM load beats, then DIM*DIM result beats from a chain of DIM
// multiply-accumulate cells, one per matrix row; loading reopens only after the last result.
// Reset clears control state only; the element stores are filled by the load beats.
module mat4_multiply_core #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // left_element[31:0], right_element[63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // product_element[31:0]
  output logic        m_axis_tlast
);
  import mat4m_pkg::*;

  localparam int CELLS = DIM * DIM;
  localparam int POS_W = $clog2(CELLS);
  localparam int E_W   = $clog2(DIM);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  typedef enum logic [1:0] {LOAD, FEED, DRAIN} state_t;

  state_t                   state;
  logic [POS_W-1:0]         load_pos;
  logic [E_W-1:0]           load_row;
  logic [E_W-1:0]           load_e;
  logic [POS_W-1:0]         feed_addr;
  logic [E_W-1:0]           feed_e;
  logic [POS_W-1:0]         out_cnt;
  logic signed [DATA_W-1:0] right_store [CELLS];
  logic                     in_acc;
  logic                     out_acc;
  logic                     adv;
  tok_t                     feed_tok;
  tok_t                     tok [DIM+1];
  wr_t                      wr [DIM];
  res_t                     res [DIM];
  logic [DIM-1:0]           done_vec;
  logic                     any_done;
  logic signed [ACC_W-1:0]  sel_acc;
  logic signed [ACC_W-1:0]  shifted;
  logic [DATA_W-1:0]        sat;

  assign s_axis_tready = (state == LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign adv           = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      right_store[load_pos] <= s_axis_tdata[63:32];
    end
    if (rst) begin
      feed_tok.valid <= 1'b0;
    end else if (adv) begin
      feed_tok.valid <= (state == FEED);
    end
    if (adv) begin
      feed_tok.b    <= right_store[feed_addr];
      feed_tok.step <= STEP_W'(feed_e);
    end
  end

  assign tok[0] = feed_tok;

  for (genvar r = 0; r < DIM; r++) begin : g_cell
    assign wr[r].en   = in_acc && (load_row == E_W'(r));
    assign wr[r].idx  = STEP_W'(load_e);
    assign wr[r].data = s_axis_tdata[31:0];
    assign done_vec[r] = res[r].done;
    mat4m_cell #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_cell (
      .clk(clk), .rst(rst), .adv(adv), .wr(wr[r]),
      .tok_in(tok[r]), .tok_out(tok[r+1]), .res(res[r])
    );
  end

  always_comb begin
    any_done = 1'b0;
    sel_acc  = '0;
    for (int r = 0; r < DIM; r++) begin
      any_done = any_done | res[r].done;
      sel_acc  = sel_acc | (res[r].done ? res[r].acc : '0);
    end
    shifted = sel_acc >>> FRAC_BITS;
    if (shifted > SAT_HI) begin
      sat = SAT_HI[DATA_W-1:0];
    end else if (shifted < SAT_LO) begin
      sat = SAT_LO[DATA_W-1:0];
    end else begin
      sat = shifted[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= LOAD;
      load_pos      <= '0;
      load_row      <= '0;
      load_e        <= '0;
      feed_addr     <= '0;
      feed_e        <= '0;
      out_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tlast  <= 1'b0;
    end else begin
      case (state)
        LOAD: begin
          if (in_acc) begin
            if (load_pos == POS_W'(CELLS - 1)) begin
              load_pos <= '0;
              load_row <= '0;
              load_e   <= '0;
              state    <= FEED;
            end else begin
              load_pos <= load_pos + POS_W'(1);
              if (load_row == E_W'(DIM - 1)) begin
                load_row <= '0;
                load_e   <= load_e + E_W'(1);
              end else begin
                load_row <= load_row + E_W'(1);
              end
            end
          end
        end
        FEED: begin
          if (adv) begin
            feed_e <= (feed_e == E_W'(DIM - 1)) ? '0 : feed_e + E_W'(1);
            if (feed_addr == POS_W'(CELLS - 1)) begin
              feed_addr <= '0;
              state     <= DRAIN;
            end else begin
              feed_addr <= feed_addr + POS_W'(1);
            end
          end
        end
        DRAIN: begin
          if (out_acc && m_axis_tlast) begin
            state <= LOAD;
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase

      if (adv) begin
        m_axis_tvalid <= any_done;
        if (any_done) begin
          m_axis_tlast <= (out_cnt == POS_W'(CELLS - 1));
          out_cnt      <= (out_cnt == POS_W'(CELLS - 1)) ? '0 : out_cnt + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && any_done) begin
      m_axis_tdata <= sat;
    end
  end

  a_done_single : assert property (@(posedge clk) disable iff (rst) $onehot0(done_vec))
    else $error("more than one cell finished in the same cycle");

  a_no_load_while_out : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("load beat open while a result is pending");

  a_last_in_drain : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (state == DRAIN))
    else $error("last result offered before feeding finished");

  a_reload_after_last : assert property (@(posedge clk) disable iff (rst)
    (out_acc && m_axis_tlast) |=> s_axis_tready)
    else $error("load not reopened after last result");

endmodule

@@ design/mat4m_cell.sv @@
module mat4m_cell #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  mat4m_pkg::wr_t    wr,
  input  mat4m_pkg::tok_t   tok_in,
  output mat4m_pkg::tok_t   tok_out,
  output mat4m_pkg::res_t   res
);
  import mat4m_pkg::*;

  localparam int E_W = $clog2(DIM);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  logic signed [DATA_W-1:0] lrow [DIM];
  logic signed [PROD_W-1:0] mul;
  logic signed [PROD_W-1:0] prod;
  logic                     pvalid;
  logic [E_W-1:0]           pstep;
  logic signed [ACC_W-1:0]  acc;
  logic                     done;

  assign mul = PROD_W'(lrow[tok_in.step[E_W-1:0]]) * PROD_W'(tok_in.b);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      lrow[wr.idx[E_W-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      pvalid  <= 1'b0;
      done    <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_in;
      pvalid  <= tok_in.valid;
      done    <= pvalid && (pstep == E_W'(DIM - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pstep <= tok_in.step[E_W-1:0];
      prod  <= mul;
      if (pvalid) begin
        if (pstep == '0) begin
          acc <= HALF + ACC_W'(prod);
        end else begin
          acc <= acc + ACC_W'(prod);
        end
      end
    end
  end

  assign res.done = done;
  assign res.acc  = acc;

endmodule
